/* sv/atrlp_pkg.sv */
// Shared types, codes and sizing for the modem response line parser.
// No dependencies; imported by atrlp_step, at_response_line_parser and tb_top.
package atrlp_pkg;

    // line store geometry
    localparam int MAX_LINES  = 8;
    localparam int LINE_BYTES = 64;
    localparam int COL_W      = $clog2(LINE_BYTES);
    localparam int LC_W       = $clog2(MAX_LINES + 1);

    // fixed port widths
    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int SLINE_W   = 3;
    localparam int SCOL_W    = 6;
    localparam int SCHAR_W   = 7;
    localparam int LCAP_W    = 4;
    localparam int STATUS_W  = 2;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
    localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_LOW   = 8'd32;
    localparam logic [BYTE_W-1:0] CH_HIGH  = 8'd126;

    typedef enum logic [VERDICT_W-1:0] {
        V_NOT_READY = 2'd0,
        V_OK        = 2'd1,
        V_ERROR     = 2'd2
    } verdict_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE  = 2'd0,
        ST_OK    = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        K_PLAIN = 2'd0,
        K_INFO  = 2'd1,
        K_SMS   = 2'd2,
        K_SPARE = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_IDLE         = 5'd0,
        PH_FIRST_LF     = 5'd1,
        PH_START        = 5'd2,
        PH_OK_K         = 5'd3,
        PH_FINAL_CR     = 5'd4,
        PH_FINAL_LF     = 5'd5,
        PH_ERR_R1       = 5'd7,
        PH_ERR_R2       = 5'd8,
        PH_ERR_O        = 5'd9,
        PH_ERR_R3       = 5'd10,
        PH_INFO         = 5'd11,
        PH_INFO_LF      = 5'd12,
        PH_INFO_NEXT    = 5'd13,
        PH_INFO_END_LF  = 5'd14,
        PH_INFO_FINAL   = 5'd15,
        PH_HDR          = 5'd16,
        PH_HDR_LF       = 5'd17,
        PH_BODY_FIRST   = 5'd18,
        PH_BODY         = 5'd19,
        PH_BODY_LF      = 5'd20,
        PH_BODY_CR      = 5'd21,
        PH_BODY_END_LF  = 5'd23,
        PH_SMS_NEXT     = 5'd24
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [COL_W-1:0] column;
        logic [LC_W-1:0]  line_count;
        status_t          status;
    } parse_state_t;

    typedef struct packed {
        verdict_t            verdict;
        logic                store_write;
        logic [SLINE_W-1:0]  store_line;
        logic [SCOL_W-1:0]   store_column;
        logic [SCHAR_W-1:0]  store_char;
        logic [LCAP_W-1:0]   lines_captured;
        status_t             final_status;
    } parse_result_t;

endpackage

/* sv/atrlp_step.sv */
// Next-state and result logic of the response grammar for one byte.
// Purely combinational; uses types and codes from atrlp_pkg.
module atrlp_step import atrlp_pkg::*; (
    input  parse_state_t      cur,
    input  kind_t             kind,
    input  logic [BYTE_W-1:0] rx_byte,
    output parse_state_t      nxt,
    output parse_result_t     res
);

    logic                printable;
    logic                put_req;
    logic                end_req;
    logic                wr_en;
    logic [LC_W-1:0]     wr_line;
    logic [COL_W-1:0]    wr_col;
    logic [SCHAR_W-1:0]  wr_char;
    verdict_t            verdict;
    parse_state_t        st;

    assign printable = (rx_byte >= CH_LOW) && (rx_byte <= CH_HIGH);

    always_comb begin
        st      = cur;
        verdict = V_NOT_READY;
        put_req = 1'b0;
        end_req = 1'b0;
        unique case (cur.phase)
            PH_IDLE: begin
                if (rx_byte == CH_CR) begin
                    st.phase      = PH_FIRST_LF;
                    st.line_count = '0;
                end
            end
            PH_FIRST_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else st.phase = (kind == K_INFO) ? PH_INFO : PH_START;
            end
            PH_START, PH_INFO_FINAL, PH_SMS_NEXT: begin
                priority if (rx_byte == CH_O) begin
                    st.phase = PH_OK_K;
                end else if (rx_byte == CH_E) begin
                    st.phase = PH_ERR_R1;
                end else if (rx_byte == CH_PLUS && cur.phase == PH_START) begin
                    if (kind == K_PLAIN)    st.phase = PH_INFO;
                    else if (kind == K_SMS) st.phase = PH_HDR;
                    else                    verdict  = V_ERROR;
                end else if (rx_byte == CH_PLUS && cur.phase == PH_SMS_NEXT) begin
                    st.phase = PH_HDR;
                end else begin
                    verdict = V_ERROR;
                end
            end
            PH_OK_K: begin
                if (rx_byte != CH_K) verdict = V_ERROR;
                else begin
                    st.status = ST_OK;
                    st.phase  = PH_FINAL_CR;
                end
            end
            PH_FINAL_CR: begin
                if (rx_byte != CH_CR) verdict = V_ERROR;
                else st.phase = PH_FINAL_LF;
            end
            PH_FINAL_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else begin
                    st.phase = PH_IDLE;
                    verdict  = V_OK;
                end
            end
            PH_ERR_R1: begin
                if (rx_byte != CH_R) verdict = V_ERROR;
                else begin
                    st.status = ST_ERROR;
                    st.phase  = PH_ERR_R2;
                end
            end
            PH_ERR_R2: begin
                if (rx_byte != CH_R) verdict = V_ERROR;
                else st.phase = PH_ERR_O;
            end
            PH_ERR_O: begin
                if (rx_byte != CH_O) verdict = V_ERROR;
                else st.phase = PH_ERR_R3;
            end
            PH_ERR_R3: begin
                // last R of ERROR reports error but still advances
                verdict = V_ERROR;
                if (rx_byte == CH_R) st.phase = PH_FINAL_CR;
            end
            PH_INFO, PH_BODY: begin
                priority if (printable) begin
                    put_req = 1'b1;
                end else if (rx_byte == CH_CR) begin
                    st.phase = (cur.phase == PH_INFO) ? PH_INFO_LF : PH_BODY_LF;
                    end_req  = 1'b1;
                end else begin
                    verdict = V_ERROR;
                end
            end
            PH_INFO_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else st.phase = PH_INFO_NEXT;
            end
            PH_INFO_NEXT: begin
                priority if (rx_byte == CH_PLUS) st.phase = PH_INFO;
                else if (rx_byte == CH_CR)      st.phase = PH_INFO_END_LF;
                else                             verdict  = V_ERROR;
            end
            PH_INFO_END_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else st.phase = PH_INFO_FINAL;
            end
            PH_HDR: begin
                priority if (printable)     put_req  = 1'b1;
                else if (rx_byte == CH_CR)  st.phase = PH_HDR_LF;
                else                        verdict  = V_ERROR;
            end
            PH_HDR_LF: begin
                // header LF is kept, header and body share one line
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else begin
                    st.phase = PH_BODY_FIRST;
                    put_req  = 1'b1;
                end
            end
            PH_BODY_FIRST: begin
                if (!printable) verdict = V_ERROR;
                else begin
                    st.phase = PH_BODY;
                    put_req  = 1'b1;
                end
            end
            PH_BODY_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else st.phase = PH_BODY_CR;
            end
            PH_BODY_CR: begin
                if (rx_byte != CH_CR) verdict = V_ERROR;
                else st.phase = PH_BODY_END_LF;
            end
            PH_BODY_END_LF: begin
                if (rx_byte != CH_LF) verdict = V_ERROR;
                else st.phase = PH_SMS_NEXT;
            end
            default: begin
                st.phase = PH_IDLE;
            end
        endcase
    end

    // line store write: bytes stop before the last column, none once store is full
    always_comb begin
        nxt     = st;
        wr_en   = 1'b0;
        wr_line = '0;
        wr_col  = '0;
        wr_char = '0;
        if (put_req && cur.line_count < LC_W'(MAX_LINES)
                && cur.column < COL_W'(LINE_BYTES - 1)) begin
            wr_en      = 1'b1;
            wr_line    = cur.line_count;
            wr_col     = cur.column;
            wr_char    = rx_byte[SCHAR_W-1:0];
            nxt.column = cur.column + 1'b1;
        end else if (end_req && cur.line_count < LC_W'(MAX_LINES)) begin
            wr_en          = 1'b1;
            wr_line        = cur.line_count;
            wr_col         = cur.column;
            nxt.line_count = cur.line_count + 1'b1;
            nxt.column     = '0;
        end
    end

    always_comb begin
        res                = '0;
        res.verdict        = verdict;
        res.store_write    = wr_en;
        res.store_line     = SLINE_W'(wr_line);
        res.store_column   = SCOL_W'(wr_col);
        res.store_char     = wr_char;
        res.lines_captured = LCAP_W'(nxt.line_count);
        res.final_status   = nxt.status;
    end

endmodule

/* sv/at_response_line_parser.sv */
// Top level of the modem response line parser: handshakes, state and result registers.
// Depends on atrlp_pkg and atrlp_step.
//
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one modem response byte
//   per word. Result channel m_valid/m_ready returns exactly one word per
//   byte: verdict, an optional line store write (line, column, char) and the
//   running line count and final OK/ERROR status.
//   cfg_wr_en/cfg_wr_data write the expected response kind; write it only
//   while no result is outstanding.
//   m_valid rises in the cycle after a byte is accepted; throughput is one byte
//   per cycle while the receiver takes each word, set by the combinational phase
//   update feeding the result register.
//   A byte is accepted whenever the result register is empty or its word is
//   taken in the same cycle, so a stalled receiver holds at most one word
//   and s_ready drops only while that word waits.
//   Reset (aresetn low, synchronous) returns the grammar to its idle phase
//   waiting for CR, clears column, line count, status and response kind,
//   and empties the result register.
module at_response_line_parser import atrlp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [KIND_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_rx_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VERDICT_W-1:0] m_verdict,
    output logic                 m_store_write,
    output logic [SLINE_W-1:0]   m_store_line,
    output logic [SCOL_W-1:0]    m_store_column,
    output logic [SCHAR_W-1:0]   m_store_char,
    output logic [LCAP_W-1:0]    m_lines_captured,
    output logic [STATUS_W-1:0]  m_final_status
);

    parse_state_t  state_reg;
    parse_state_t  state_next;
    parse_result_t result_reg;
    parse_result_t result_next;
    kind_t         kind_reg;
    logic          m_valid_reg;
    logic          s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    atrlp_step u_step (
        .cur     (state_reg),
        .kind    (kind_reg),
        .rx_byte (s_rx_byte),
        .nxt     (state_next),
        .res     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{phase: PH_IDLE, column: '0, line_count: '0, status: ST_NONE};
            kind_reg    <= K_PLAIN;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) kind_reg <= kind_t'(cfg_wr_data);
            if (s_fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload word, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) result_reg <= result_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_verdict        = result_reg.verdict;
    assign m_store_write    = result_reg.store_write;
    assign m_store_line     = result_reg.store_line;
    assign m_store_column   = result_reg.store_column;
    assign m_store_char     = result_reg.store_char;
    assign m_lines_captured = result_reg.lines_captured;
    assign m_final_status   = result_reg.final_status;

    // error leaves the grammar state alone, except the last R of ERROR
    a_error_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && result_next.verdict == V_ERROR && state_reg.phase != PH_ERR_R3
        |=> state_reg == $past(state_reg))
        else $error("state changed on error verdict");

    a_ok_from_final_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && result_next.verdict == V_OK |-> state_reg.phase == PH_FINAL_LF)
        else $error("OK verdict outside final LF");

    a_quiet_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_store_write
        |-> m_store_line == '0 && m_store_column == '0 && m_store_char == '0)
        else $error("store fields set without a write");

    a_line_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.line_count <= LC_W'(MAX_LINES))
        else $error("line count beyond store size");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for at_response_line_parser: drives modem response bytes
// through valid/ready, predicts every result word and compares it field by field.
// Depends on atrlp_pkg and the parser RTL only.
module tb_top;
    import atrlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 30;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [KIND_W-1:0]    cfg_wr_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [VERDICT_W-1:0] m_verdict;
    logic                 m_store_write;
    logic [SLINE_W-1:0]   m_store_line;
    logic [SCOL_W-1:0]    m_store_column;
    logic [SCHAR_W-1:0]   m_store_char;
    logic [LCAP_W-1:0]    m_lines_captured;
    logic [STATUS_W-1:0]  m_final_status;

    at_response_line_parser uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_verdict        (m_verdict),
        .m_store_write    (m_store_write),
        .m_store_line     (m_store_line),
        .m_store_column   (m_store_column),
        .m_store_char     (m_store_char),
        .m_lines_captured (m_lines_captured),
        .m_final_status   (m_final_status)
    );

    // grammar tracker, mirrors the parser state
    phase_t           ph       = PH_IDLE;
    logic [COL_W-1:0] col      = '0;
    logic [LC_W-1:0]  lines    = '0;
    status_t          status_q = ST_NONE;
    kind_t            kind_q   = K_PLAIN;
    parse_result_t    next_word;

    parse_result_t expected_words[$];

    int n_sent     = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int noise_pct  = 0;
    int long_pct   = 4;
    int hold_req   = 0;
    int idle_count = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic bit is_printable(input logic [BYTE_W-1:0] b);
        return b >= CH_LOW && b <= CH_HIGH;
    endfunction

    function automatic void store_byte(input logic [BYTE_W-1:0] b);
        if (lines < MAX_LINES && col < LINE_BYTES - 1) begin
            next_word.store_write  = 1'b1;
            next_word.store_line   = lines[SLINE_W-1:0];
            next_word.store_column = col;
            next_word.store_char   = b[SCHAR_W-1:0];
            col++;
        end
    endfunction

    function automatic void close_line();
        if (lines < MAX_LINES && col < LINE_BYTES) begin
            next_word.store_write  = 1'b1;
            next_word.store_line   = lines[SLINE_W-1:0];
            next_word.store_column = col;
            next_word.store_char   = '0;
            lines++;
            col = '0;
        end
    endfunction

    // one step of the response grammar; an error leaves the state alone, except at the last R of ERROR
    function automatic parse_result_t predict_word(input logic [BYTE_W-1:0] b);
        verdict_t v;
        v = V_NOT_READY;
        next_word = '0;
        case (ph)
            PH_IDLE: if (b == CH_CR) begin
                ph = PH_FIRST_LF;
                lines = '0;
            end
            PH_FIRST_LF: begin
                if (b != CH_LF) v = V_ERROR;
                else ph = (kind_q == K_INFO) ? PH_INFO : PH_START;
            end
            PH_START, PH_INFO_FINAL, PH_SMS_NEXT: begin
                if (b == CH_O) ph = PH_OK_K;
                else if (b == CH_E) ph = PH_ERR_R1;
                else if (b == CH_PLUS && ph == PH_START && kind_q == K_PLAIN) ph = PH_INFO;
                else if (b == CH_PLUS && ph == PH_START && kind_q == K_SMS) ph = PH_HDR;
                else if (b == CH_PLUS && ph == PH_SMS_NEXT) ph = PH_HDR;
                else v = V_ERROR;
            end
            PH_OK_K: begin
                if (b != CH_K) v = V_ERROR;
                else begin
                    status_q = ST_OK;
                    ph = PH_FINAL_CR;
                end
            end
            PH_FINAL_CR: if (b != CH_CR) v = V_ERROR; else ph = PH_FINAL_LF;
            PH_FINAL_LF: begin
                if (b != CH_LF) v = V_ERROR;
                else begin
                    ph = PH_IDLE;
                    v = V_OK;
                end
            end
            PH_ERR_R1: begin
                if (b != CH_R) v = V_ERROR;
                else begin
                    status_q = ST_ERROR;
                    ph = PH_ERR_R2;
                end
            end
            PH_ERR_R2: if (b != CH_R) v = V_ERROR; else ph = PH_ERR_O;
            PH_ERR_O: if (b != CH_O) v = V_ERROR; else ph = PH_ERR_R3;
            PH_ERR_R3: begin
                // last R of ERROR answers error but still advances
                v = V_ERROR;
                if (b == CH_R) ph = PH_FINAL_CR;
            end
            PH_INFO, PH_BODY: begin
                if (is_printable(b)) store_byte(b);
                else if (b == CH_CR) begin
                    ph = (ph == PH_INFO) ? PH_INFO_LF : PH_BODY_LF;
                    close_line();
                end else v = V_ERROR;
            end
            PH_INFO_LF: if (b != CH_LF) v = V_ERROR; else ph = PH_INFO_NEXT;
            PH_INFO_NEXT: begin
                if (b == CH_PLUS) ph = PH_INFO;
                else if (b == CH_CR) ph = PH_INFO_END_LF;
                else v = V_ERROR;
            end
            PH_INFO_END_LF: if (b != CH_LF) v = V_ERROR; else ph = PH_INFO_FINAL;
            PH_HDR: begin
                if (is_printable(b)) store_byte(b);
                else if (b == CH_CR) ph = PH_HDR_LF;
                else v = V_ERROR;
            end
            PH_HDR_LF: begin
                // header LF lands in the store, header and body share a line
                if (b != CH_LF) v = V_ERROR;
                else begin
                    ph = PH_BODY_FIRST;
                    store_byte(b);
                end
            end
            PH_BODY_FIRST: begin
                if (!is_printable(b)) v = V_ERROR;
                else begin
                    ph = PH_BODY;
                    store_byte(b);
                end
            end
            PH_BODY_LF: if (b != CH_LF) v = V_ERROR; else ph = PH_BODY_CR;
            PH_BODY_CR: if (b != CH_CR) v = V_ERROR; else ph = PH_BODY_END_LF;
            PH_BODY_END_LF: if (b != CH_LF) v = V_ERROR; else ph = PH_SMS_NEXT;
            default: ph = PH_IDLE;
        endcase
        next_word.verdict        = v;
        next_word.lines_captured = lines;
        next_word.final_status   = status_q;
        return next_word;
    endfunction

    // byte that walks the grammar toward idle from a given phase
    function automatic logic [BYTE_W-1:0] resync_byte(input phase_t p);
        case (p)
            PH_START, PH_INFO_FINAL, PH_SMS_NEXT, PH_ERR_O, PH_BODY_FIRST: return CH_O;
            PH_OK_K: return CH_K;
            PH_ERR_R1, PH_ERR_R2, PH_ERR_R3: return CH_R;
            PH_FIRST_LF, PH_FINAL_LF, PH_INFO_LF, PH_INFO_END_LF,
            PH_HDR_LF, PH_BODY_LF, PH_BODY_END_LF: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < long_pct) return $urandom_range(60, 75);
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    // one word over the input channel; called and returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(predict_word(b));
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_item(input logic [BYTE_W-1:0] b);
        if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        send_byte(b);
    endtask

    task automatic send_text(input int len);
        for (int i = 0; i < len; i++)
            send_item(BYTE_W'($urandom_range(CH_LOW, CH_HIGH)));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_kind(input kind_t k);
        wait_drained();
        cfg_wr_data <= k;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        kind_q = k;
    endtask

    // n is info lines for plain/info kinds, messages for the sms kind
    task automatic send_response(input kind_t k, input int n);
        int guard;
        if ($urandom_range(0, 4) == 0) send_byte(BYTE_W'($urandom_range(0, 255)));
        send_item(CH_CR);
        send_item(CH_LF);
        case (k)
            K_PLAIN, K_INFO: begin
                if (k == K_INFO && n == 0) n = 1;
                for (int i = 0; i < n; i++) begin
                    if (!(k == K_INFO && i == 0)) send_item(CH_PLUS);
                    send_text(pick_len());
                    send_item(CH_CR);
                    send_item(CH_LF);
                end
                if (n > 0) begin
                    send_item(CH_CR);
                    send_item(CH_LF);
                end
            end
            K_SMS: begin
                for (int i = 0; i < n; i++) begin
                    send_item(CH_PLUS);
                    send_text(pick_len());
                    send_item(CH_CR);
                    send_item(CH_LF);
                    send_text(1 + pick_len());
                    send_item(CH_CR);
                    send_item(CH_LF);
                    send_item(CH_CR);
                    send_item(CH_LF);
                end
            end
            default: if ($urandom_range(0, 3) == 0) send_item(CH_PLUS);
        endcase
        if ($urandom_range(0, 2) == 0) begin
            send_item(CH_E);
            send_item(CH_R);
            send_item(CH_R);
            send_item(CH_O);
            send_item(CH_R);
        end else begin
            send_item(CH_O);
            send_item(CH_K);
        end
        send_item(CH_CR);
        send_item(CH_LF);
        // noise may have derailed the grammar; walk it back to idle
        guard = 0;
        while (ph != PH_IDLE && guard < 40) begin
            send_byte(resync_byte(ph));
            guard++;
        end
    endtask

    task automatic run_responses(input kind_t k, input int until_sent);
        int n;
        write_kind(k);
        while (n_sent < until_sent) begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : 20;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 20;
            noise_pct = ($urandom_range(0, 3) == 0) ? 0 : 3;
            if (k == K_SMS)
                n = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(0, 2);
            else
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 3);
            send_response(k, n);
        end
    endtask

    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        noise_pct = 0;
        write_kind(K_PLAIN);
        send_byte(8'h00);       // ignored while idle
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(8'h80);       // not LF after CR
        send_byte(CH_LF);
        send_byte(CH_PLUS);     // opening plus is not stored
        send_byte(8'h7F);       // control byte inside a line
        send_byte(CH_LOW);
        send_byte(CH_HIGH);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_O);
        send_byte(CH_K);
        send_byte(CH_CR);
        send_byte(CH_LF);
        write_kind(K_SPARE);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_PLUS);     // refused by the spare kind
        send_byte(CH_E);
        send_byte(CH_R);
        send_byte(CH_R);
        send_byte(CH_O);
        send_byte(CH_R);
        send_byte(CH_CR);
        send_byte(CH_LF);
    endtask

    task automatic test_plain(input int until_sent);
        run_responses(K_PLAIN, until_sent);
    endtask

    task automatic test_info(input int until_sent);
        run_responses(K_INFO, until_sent);
    endtask

    task automatic test_sms(input int until_sent);
        run_responses(K_SMS, until_sent);
    endtask

    task automatic test_spare(input int until_sent);
        run_responses(K_SPARE, until_sent);
    endtask

    // more lines than the store holds, and lines longer than a store row
    task automatic test_store_limits();
        noise_pct = 0;
        gap_pct   = 10;
        stall_pct = 10;
        write_kind(K_PLAIN);
        send_response(K_PLAIN, 10);
        write_kind(K_SMS);
        send_response(K_SMS, 9);
        write_kind(K_INFO);
        send_response(K_INFO, 10);
        long_pct = 100;
        send_response(K_INFO, 2);
        long_pct = 4;
    endtask

    // receiver holds off so the block backs up, then the sender pauses
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        noise_pct = 0;
        write_kind(K_SMS);
        hold_req = 60;
        send_response(K_SMS, 2);
        wait_drained();
        send_response(K_SMS, 1);
        wait_drained();
        hold_req = 40;
        send_response(K_SMS, 1);
    endtask

    task automatic test_no_idling(input int until_sent);
        kind_t k;
        gap_pct   = 0;
        stall_pct = 0;
        noise_pct = 3;
        while (n_sent < until_sent) begin
            k = kind_t'($urandom_range(0, 3));
            write_kind(k);
            send_response(k, (k == K_SMS) ? $urandom_range(0, 2) : $urandom_range(0, 3));
        end
    endtask

    // receiver: random stall bursts, plus long hold-offs on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                m_ready <= 1'b0;
                repeat (hold_req) @(negedge aclk);
                hold_req = 0;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        parse_result_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending", m_verdict, 0);
            end else begin
                w = expected_words.pop_front();
                n_checked++;
                if (m_verdict !== w.verdict)
                    report_mismatch("verdict", m_verdict, w.verdict);
                if (m_store_write !== w.store_write)
                    report_mismatch("store_write", m_store_write, w.store_write);
                if (m_store_line !== w.store_line)
                    report_mismatch("store_line", m_store_line, w.store_line);
                if (m_store_column !== w.store_column)
                    report_mismatch("store_column", m_store_column, w.store_column);
                if (m_store_char !== w.store_char)
                    report_mismatch("store_char", m_store_char, w.store_char);
                if (m_lines_captured !== w.lines_captured)
                    report_mismatch("lines_captured", m_lines_captured, w.lines_captured);
                if (m_final_status !== w.final_status)
                    report_mismatch("final_status", m_final_status, w.final_status);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d words still pending", expected_words.size());
            $display("tb: failure");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_rx_byte   = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_plain(450);
        test_info(800);
        test_sms(1200);
        test_spare(1300);
        test_store_limits();
        test_backpressure();
        test_no_idling(1850);
        wait_drained();

        $display("run: %0d bytes sent, %0d result words checked, %0d mismatches",
                 n_sent, n_checked, n_errors);
        $display("run: plain, info, sms and spare kinds; noise; full store; long lines; stalls");
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* at_response_line_parser.f */
sv/atrlp_pkg.sv
sv/atrlp_step.sv
sv/at_response_line_parser.sv
tb/sv/tb_top.sv
